// ===== rtl/core/bsc_pkg.sv =====
// ----------------------------------------------------------------------------
// bsc_pkg: shared types and constants of the safety check block
// Field widths, table geometry, function codes, sequencer states and the
// write beats that travel between the sequencer and the table memories.
// ----------------------------------------------------------------------------
package bsc_pkg;

	localparam int MAX_PROCS = 16;
	localparam int MAX_RES   = 16;
	localparam int PROC_W    = 4;
	localparam int RES_W     = 4;
	localparam int AMT_W     = 8;
	localparam int NEED_W    = AMT_W + 1;
	localparam int WORK_W    = 13;
	localparam int CNT_W     = 5;
	localparam int ADDR_W    = PROC_W + RES_W;
	localparam int DEPTH     = MAX_PROCS * MAX_RES;
	localparam int CFG_W     = 5;

	localparam logic REG_NUM_PROCS = 1'b0;
	localparam logic REG_NUM_RES   = 1'b1;

	typedef enum logic [1:0] {
		FUNC_ALLOC = 2'd0,
		FUNC_MAX   = 2'd1,
		FUNC_AVAIL = 2'd2,
		FUNC_RUN   = 2'd3
	} func_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NEED_RD,
		ST_NEED_WR,
		ST_NEXT,
		ST_CHK_RD,
		ST_CHK_CMP,
		ST_ADD_RD,
		ST_ADD_WR,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [AMT_W-1:0]  data;
	} alloc_wr_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [NEED_W-1:0] data;
	} need_wr_t;

	typedef struct packed {
		logic [WORK_W-1:0] sum;
		logic              fits;
	} alu_res_t;

endpackage

// ===== rtl/core/bsc_tables.sv =====
// ----------------------------------------------------------------------------
// bsc_tables: allocation and need table memories
// One write and one registered read per table each cycle. After reset a
// clearing pass writes zero to every entry, one address per cycle.
// ----------------------------------------------------------------------------
module bsc_tables
	import bsc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  alloc_wr_t         alloc_wr,
	input  logic [ADDR_W-1:0] alloc_raddr,
	output logic [AMT_W-1:0]  alloc_rdata,
	input  need_wr_t          need_wr,
	input  logic [ADDR_W-1:0] need_raddr,
	output logic [NEED_W-1:0] need_rdata,
	output logic              clearing
);

	logic [AMT_W-1:0]  alloc_mem [DEPTH];
	logic [NEED_W-1:0] need_mem  [DEPTH];
	logic [AMT_W-1:0]  alloc_rd_q;
	logic [NEED_W-1:0] need_rd_q;
	logic [ADDR_W:0]   clr_cnt_q;
	logic [ADDR_W-1:0] clr_addr;

	// top bit sets once every entry has been zeroed
	assign clearing = !clr_cnt_q[ADDR_W];
	assign clr_addr = clr_cnt_q[ADDR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_cnt_q <= '0;
		else if (clearing) clr_cnt_q <= clr_cnt_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (clearing) begin
			alloc_mem[clr_addr] <= '0;
			need_mem[clr_addr]  <= '0;
		end else begin
			if (alloc_wr.we) alloc_mem[alloc_wr.addr] <= alloc_wr.data;
			if (need_wr.we) need_mem[need_wr.addr] <= need_wr.data;
		end
		alloc_rd_q <= alloc_mem[alloc_raddr];
		need_rd_q  <= need_mem[need_raddr];
	end

	assign alloc_rdata = alloc_rd_q;
	assign need_rdata  = need_rd_q;

endmodule

// ===== rtl/core/bsc_alu.sv =====
// ----------------------------------------------------------------------------
// bsc_alu: shared compare and add unit
// Compares one signed need against one working amount and adds one
// allocation to it, modulo the working width.
// ----------------------------------------------------------------------------
module bsc_alu
	import bsc_pkg::*;
(
	input  logic [WORK_W-1:0] work,
	input  logic [AMT_W-1:0]  alloc,
	input  logic [NEED_W-1:0] need,
	output alu_res_t          res
);

	logic signed [WORK_W:0] need_x;
	logic signed [WORK_W:0] work_x;

	always_comb begin
		need_x   = {{(WORK_W + 1 - NEED_W){need[NEED_W-1]}}, need};
		work_x   = {1'b0, work};
		res.fits = (need_x <= work_x);
		res.sum  = work + {{(WORK_W - AMT_W){1'b0}}, alloc};
	end

endmodule

// ===== rtl/core/bankers_safety_check_top.sv =====
// ----------------------------------------------------------------------------
// bankers_safety_check_top: deadlock-avoidance safety check
// Command beats load allocation, maximum demand or available amounts, or
// start a check run that emits the safe process sequence.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat is taken when start is high and busy is low.
//   Allocation and available loads are written as the beat is taken. A
//   maximum-demand load reads the allocation entry first, then writes the need.
//   A run copies the available vector, then walks processes pass after pass.
//   Each unfinished process is checked resource by resource up to the
//   first misfit; when all fit, its allocations are added to the work
//   vector one resource at a time and it finishes; a pass with no finish ends
//   the run; one compare/add unit and one read port per table serialise it.
//   Results leave on strobe, one cycle each; the receiver cannot stall.
//   One result is held back so the final one carries last and safe; a run
//   where nothing finishes gives one result with has_proc low.
//   Config writes (cfg_we) are taken at any edge and belong in idle time.
//   Reset clears the counts and the sequencer; a clearing pass then zeroes
//   the tables, with busy held high meanwhile.
// ----------------------------------------------------------------------------
module bankers_safety_check_top
	import bsc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        func,
	input  logic [PROC_W-1:0] proc_index,
	input  logic [RES_W-1:0]  res_index,
	input  logic [AMT_W-1:0]  amount,
	output logic              strobe,
	output logic              has_proc,
	output logic [PROC_W-1:0] proc_out,
	output logic              safe,
	output logic              last
);

	state_t state_q, state_d;

	logic [CNT_W-1:0]     np_q, nr_q;
	logic [CNT_W-1:0]     i_q, j_q;
	logic [MAX_PROCS-1:0] fin_q;
	logic                 chg_q;
	logic                 pend_vld_q;
	logic [PROC_W-1:0]    pend_q;
	logic [PROC_W-1:0]    p_q;
	logic [RES_W-1:0]     r_q;
	logic [AMT_W-1:0]     amt_q;
	logic [AMT_W-1:0]     avail_q [MAX_RES];
	logic [WORK_W-1:0]    work_q  [MAX_RES];
	logic                 strobe_q, has_q, safe_q, last_q;
	logic [PROC_W-1:0]    proc_q;

	logic                 accept;
	logic                 tbl_clearing;
	func_t                func_c;
	alloc_wr_t            alloc_wr;
	need_wr_t             need_wr;
	logic [ADDR_W-1:0]    alloc_raddr, ij_addr;
	logic [AMT_W-1:0]     alloc_rdata;
	logic [NEED_W-1:0]    need_rdata;
	alu_res_t             alu_res;
	logic [MAX_PROCS-1:0] in_use;
	logic                 all_done;

	assign busy    = (state_q != ST_IDLE) || tbl_clearing;
	assign accept  = start && !busy;
	assign func_c  = func_t'(func);
	assign ij_addr = {i_q[PROC_W-1:0], j_q[RES_W-1:0]};

	always_comb begin
		for (int k = 0; k < MAX_PROCS; k++) in_use[k] = (CNT_W'(k) < np_q);
		all_done = &(fin_q | ~in_use);
	end

	always_comb begin
		alloc_wr.we   = accept && (func_c == FUNC_ALLOC);
		alloc_wr.addr = {proc_index, res_index};
		alloc_wr.data = amount;
		need_wr.we    = (state_q == ST_NEED_WR);
		need_wr.addr  = {p_q, r_q};
		need_wr.data  = {1'b0, amt_q} - {1'b0, alloc_rdata};
		alloc_raddr   = (state_q == ST_NEED_RD) ? {p_q, r_q} : ij_addr;
	end

	bsc_tables u_tables (
		.clk         (clk),
		.arst_n      (arst_n),
		.alloc_wr    (alloc_wr),
		.alloc_raddr (alloc_raddr),
		.alloc_rdata (alloc_rdata),
		.need_wr     (need_wr),
		.need_raddr  (ij_addr),
		.need_rdata  (need_rdata),
		.clearing    (tbl_clearing)
	);

	bsc_alu u_alu (
		.work  (work_q[j_q[RES_W-1:0]]),
		.alloc (alloc_rdata),
		.need  (need_rdata),
		.res   (alu_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (func_c)
						FUNC_MAX:   state_d = ST_NEED_RD;
						FUNC_RUN:   state_d = ST_NEXT;
						FUNC_ALLOC,
						FUNC_AVAIL: state_d = ST_IDLE;
					endcase
				end
			end
			ST_NEED_RD: state_d = ST_NEED_WR;
			ST_NEED_WR: state_d = ST_IDLE;
			ST_NEXT: begin
				priority if (i_q == np_q) state_d = chg_q ? ST_NEXT : ST_FINISH;
				else if (fin_q[i_q[PROC_W-1:0]]) state_d = ST_NEXT;
				else state_d = ST_CHK_RD;
			end
			ST_CHK_RD:  state_d = (j_q == nr_q) ? ST_ADD_RD : ST_CHK_CMP;
			ST_CHK_CMP: state_d = alu_res.fits ? ST_CHK_RD : ST_NEXT;
			ST_ADD_RD:  state_d = (j_q == nr_q) ? ST_NEXT : ST_ADD_WR;
			ST_ADD_WR:  state_d = ST_ADD_RD;
			ST_FINISH:  state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && func_c == FUNC_MAX) begin
			p_q   <= proc_index;
			r_q   <= res_index;
			amt_q <= amount;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			np_q       <= '0;
			nr_q       <= '0;
			i_q        <= '0;
			j_q        <= '0;
			fin_q      <= '0;
			chg_q      <= 1'b0;
			pend_vld_q <= 1'b0;
			pend_q     <= '0;
			strobe_q   <= 1'b0;
			has_q      <= 1'b0;
			proc_q     <= '0;
			safe_q     <= 1'b0;
			last_q     <= 1'b0;
			for (int k = 0; k < MAX_RES; k++) begin
				avail_q[k] <= '0;
				work_q[k]  <= '0;
			end
		end else begin
			strobe_q <= 1'b0;
			if (cfg_we) begin
				// counts above the table size clamp to it
				unique case (cfg_index)
					REG_NUM_PROCS: np_q <= (cfg_data > CFG_W'(MAX_PROCS)) ?
						CNT_W'(MAX_PROCS) : cfg_data;
					REG_NUM_RES:   nr_q <= (cfg_data > CFG_W'(MAX_RES)) ?
						CNT_W'(MAX_RES) : cfg_data;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && func_c == FUNC_AVAIL) avail_q[res_index] <= amount;
					if (accept && func_c == FUNC_RUN) begin
						fin_q      <= '0;
						chg_q      <= 1'b0;
						i_q        <= '0;
						pend_vld_q <= 1'b0;
						for (int k = 0; k < MAX_RES; k++)
							work_q[k] <= {{(WORK_W - AMT_W){1'b0}}, avail_q[k]};
					end
				end
				ST_NEXT: begin
					priority if (i_q == np_q) begin
						if (chg_q) begin
							i_q   <= '0;
							chg_q <= 1'b0;
						end
					end else if (fin_q[i_q[PROC_W-1:0]]) begin
						i_q <= i_q + 1'b1;
					end else begin
						j_q <= '0;
					end
				end
				ST_CHK_RD: begin
					if (j_q == nr_q) j_q <= '0;
				end
				ST_CHK_CMP: begin
					if (alu_res.fits) j_q <= j_q + 1'b1;
					else i_q <= i_q + 1'b1;
				end
				ST_ADD_RD: begin
					if (j_q == nr_q) begin
						// process done: release the held result, hold this one
						fin_q[i_q[PROC_W-1:0]] <= 1'b1;
						chg_q      <= 1'b1;
						i_q        <= i_q + 1'b1;
						pend_q     <= i_q[PROC_W-1:0];
						pend_vld_q <= 1'b1;
						if (pend_vld_q) begin
							strobe_q <= 1'b1;
							has_q    <= 1'b1;
							proc_q   <= pend_q;
							safe_q   <= 1'b0;
							last_q   <= 1'b0;
						end
					end
				end
				ST_ADD_WR: begin
					work_q[j_q[RES_W-1:0]] <= alu_res.sum;
					j_q <= j_q + 1'b1;
				end
				ST_FINISH: begin
					strobe_q <= 1'b1;
					has_q    <= pend_vld_q;
					proc_q   <= pend_vld_q ? pend_q : '0;
					safe_q   <= all_done;
					last_q   <= 1'b1;
				end
				ST_NEED_RD, ST_NEED_WR: ;
				default: ;
			endcase
		end
	end

	assign strobe   = strobe_q;
	assign has_proc = has_q;
	assign proc_out = proc_q;
	assign safe     = safe_q;
	assign last     = last_q;

`ifndef ASSERT_OFF
	a_mid_beat_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last) |-> busy)
		else $error("non-final result beat outside a run");
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !has_proc) |-> last)
		else $error("empty result beat not marked last");
	a_no_beat_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !strobe)
		else $error("result beat right after a command");
	a_safe_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && safe) |-> last)
		else $error("safe flag on a non-final beat");
`endif

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the banker's safety check block
// Loads allocation, maximum-demand and available amounts, writes the process
// and resource counts between phases, and starts check runs. A scoreboard
// tracks the tables, works out the safe sequence of each run and compares
// every result beat with it as it leaves the block.
// ----------------------------------------------------------------------------
module tb;
	import bsc_pkg::*;

	localparam int ITEM_TARGET   = 180;
	localparam int RESULT_TARGET = 40;
	localparam int SETTLE_CYCLES = 6;
	localparam int STALL_LIMIT   = 20000;

	typedef struct packed {
		logic              has_proc;
		logic [PROC_W-1:0] proc_out;
		logic              safe;
		logic              last;
	} seq_beat_t;

	class bsc_scoreboard;
		logic [AMT_W-1:0]         alloc_tbl [DEPTH];
		logic signed [NEED_W-1:0] need_tbl  [DEPTH];
		logic [AMT_W-1:0]         avail_vec [MAX_RES];
		logic [CFG_W-1:0]         proc_cnt;
		logic [CFG_W-1:0]         res_cnt;
		seq_beat_t                seq_q [$];
		int                       mismatches;

		function new();
			for (int k = 0; k < DEPTH; k++) begin
				alloc_tbl[k] = '0;
				need_tbl[k]  = '0;
			end
			for (int k = 0; k < MAX_RES; k++)
				avail_vec[k] = '0;
			proc_cnt   = '0;
			res_cnt    = '0;
			mismatches = 0;
		endfunction

		function void set_reg(logic idx, logic [CFG_W-1:0] val);
			if (idx == REG_NUM_PROCS)
				proc_cnt = val;
			else
				res_cnt = val;
		endfunction

		function void note_beat(func_t f, logic [PROC_W-1:0] p, logic [RES_W-1:0] r,
				logic [AMT_W-1:0] a);
			case (f)
				FUNC_ALLOC: alloc_tbl[{p, r}] = a;
				// need is frozen against the allocation held right now
				FUNC_MAX:   need_tbl[{p, r}] = $signed({1'b0, a}) -
						$signed({1'b0, alloc_tbl[{p, r}]});
				FUNC_AVAIL: avail_vec[r] = a;
				default:    predict_sequence();
			endcase
		endfunction

		function void predict_sequence();
			int                   np;
			int                   nr;
			int                   cnt;
			bit                   changed;
			bit                   fits;
			bit                   all_done;
			logic [WORK_W-1:0]    work [MAX_RES];
			logic [MAX_PROCS-1:0] done;
			logic [PROC_W-1:0]    order [MAX_PROCS];
			seq_beat_t            b;
			np = (proc_cnt > MAX_PROCS) ? MAX_PROCS : proc_cnt;
			nr = (res_cnt > MAX_RES) ? MAX_RES : res_cnt;
			for (int j = 0; j < MAX_RES; j++)
				work[j] = WORK_W'(avail_vec[j]);
			done = '0;
			cnt  = 0;
			do begin
				changed = 1'b0;
				for (int i = 0; i < np; i++) begin
					if (done[i])
						continue;
					fits = 1'b1;
					for (int j = 0; j < nr; j++)
						if (need_tbl[i*MAX_RES+j] > $signed({1'b0, work[j]}))
							fits = 1'b0;
					if (!fits)
						continue;
					done[i] = 1'b1;
					changed = 1'b1;
					for (int j = 0; j < nr; j++)
						work[j] = work[j] + WORK_W'(alloc_tbl[i*MAX_RES+j]);
					order[cnt] = PROC_W'(i);
					cnt++;
				end
			end while (changed);
			all_done = (np == 0) || (int'(done) == (1 << np) - 1);
			if (cnt == 0) begin
				b.has_proc = 1'b0;
				b.proc_out = '0;
				b.safe     = all_done;
				b.last     = 1'b1;
				seq_q.push_back(b);
			end
			for (int k = 0; k < cnt; k++) begin
				b.has_proc = 1'b1;
				b.proc_out = order[k];
				b.safe     = (k == cnt - 1) ? all_done : 1'b0;
				b.last     = (k == cnt - 1);
				seq_q.push_back(b);
			end
		endfunction

		function void check_beat(seq_beat_t got);
			seq_beat_t want;
			if (seq_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: has_proc=%0d proc=%0d safe=%0d last=%0d",
						got.has_proc, got.proc_out, got.safe, got.last);
				return;
			end
			want = seq_q.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"result mismatch: expected has_proc=%0d proc=%0d ",
						"safe=%0d last=%0d, got has_proc=%0d proc=%0d safe=%0d last=%0d"},
						want.has_proc, want.proc_out, want.safe, want.last,
						got.has_proc, got.proc_out, got.safe, got.last);
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic              cfg_index;
	logic [CFG_W-1:0]  cfg_data;
	logic              start;
	logic              busy;
	logic [1:0]        func;
	logic [PROC_W-1:0] proc_index;
	logic [RES_W-1:0]  res_index;
	logic [AMT_W-1:0]  amount;
	logic              strobe;
	logic              has_proc;
	logic [PROC_W-1:0] proc_out;
	logic              safe;
	logic              last;

	bsc_scoreboard board;
	int            n_items;
	int            n_results;
	int            stall_cycles = 0;
	bit            idle_on;

	bankers_safety_check_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.proc_index (proc_index),
		.res_index  (res_index),
		.amount     (amount),
		.strobe     (strobe),
		.has_proc   (has_proc),
		.proc_out   (proc_out),
		.safe       (safe),
		.last       (last)
	);

	always #2 clk = ~clk;

	// check before noting: an old run's last beat may share an edge with a new command
	always @(posedge clk) begin
		if (arst_n) begin
			if (strobe) begin
				board.check_beat({has_proc, proc_out, safe, last});
				n_results++;
			end
			if (start && !busy)
				board.note_beat(func_t'(func), proc_index, res_index, amount);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || strobe || (start && !busy) || cfg_we) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic send(func_t f, logic [PROC_W-1:0] p, logic [RES_W-1:0] r,
			logic [AMT_W-1:0] a);
		start      <= 1'b1;
		func       <= f;
		proc_index <= p;
		res_index  <= r;
		amount     <= a;
		@(posedge clk);
		while (busy) @(posedge clk);
		n_items++;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic send_noise();
		send(func_t'($urandom_range(0, 2)), PROC_W'($urandom_range(0, 15)),
			RES_W'($urandom_range(0, 15)), AMT_W'($urandom_range(0, 255)));
	endtask

	// wait for every pending beat, then let a trailing load finish
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (board.seq_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_regs(logic [CFG_W-1:0] np, logic [CFG_W-1:0] nr);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= REG_NUM_PROCS;
		cfg_data  <= np;
		@(posedge clk);
		cfg_index <= REG_NUM_RES;
		cfg_data  <= nr;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_reg(REG_NUM_PROCS, np);
		board.set_reg(REG_NUM_RES, nr);
	endtask

	task automatic run_scenario();
		logic [CFG_W-1:0] np;
		logic [CFG_W-1:0] nr;
		int               lp;
		int               lr;
		int               amax;
		int               m;
		np = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(16, 31))
			: CFG_W'($urandom_range(0, 6));
		nr = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(16, 31))
			: CFG_W'($urandom_range(0, 4));
		write_regs(np, nr);
		idle_on = (n_items < ITEM_TARGET - 30) && ($urandom_range(0, 2) != 0);
		lp      = (np > 6) ? 6 : np;
		lr      = (nr > 4) ? 4 : nr;
		amax    = ($urandom_range(0, 4) == 0) ? 255 : 7;
		for (int p = 0; p < lp; p++)
			for (int r = 0; r < lr; r++) begin
				send(FUNC_ALLOC, PROC_W'(p), RES_W'(r), AMT_W'($urandom_range(0, amax)));
				if ($urandom_range(0, 9) == 0)
					send_noise();
			end
		for (int p = 0; p < lp; p++)
			for (int r = 0; r < lr; r++) begin
				// mostly a maximum at or above the allocation, now and then below it
				if ($urandom_range(0, 5) == 0)
					m = $urandom_range(0, amax);
				else
					m = board.alloc_tbl[p*MAX_RES+r] + $urandom_range(0, amax);
				send(FUNC_MAX, PROC_W'(p), RES_W'(r), AMT_W'((m > 255) ? 255 : m));
				if ($urandom_range(0, 9) == 0)
					send_noise();
			end
		for (int r = 0; r < lr; r++)
			send(FUNC_AVAIL, PROC_W'($urandom_range(0, 15)), RES_W'(r),
				AMT_W'($urandom_range(0, amax)));
		if ($urandom_range(0, 2) == 0)
			settle();
		send(FUNC_RUN, PROC_W'($urandom_range(0, 15)), RES_W'($urandom_range(0, 15)),
			AMT_W'($urandom_range(0, 255)));
		if ($urandom_range(0, 1) == 0) begin
			send(FUNC_AVAIL, '0, RES_W'($urandom_range(0, (lr > 0) ? lr - 1 : 0)),
				AMT_W'($urandom_range(0, amax)));
			send(FUNC_RUN, '0, '0, '0);
		end
	endtask

	initial begin
		board        = new();
		clk          = 1'b0;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = REG_NUM_PROCS;
		cfg_data     = '0;
		start        = 1'b0;
		func         = FUNC_ALLOC;
		proc_index   = '0;
		res_index    = '0;
		amount       = '0;
		n_items      = 0;
		n_results    = 0;
		idle_on      = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no processes: vacuously safe, one beat without a process
		write_regs(5'd0, 5'd0);
		send(FUNC_RUN, 4'd15, 4'd15, 8'd255);
		// no resource types: everyone fits in the first pass
		write_regs(5'd2, 5'd0);
		send(FUNC_RUN, '0, '0, '0);
		// negative need, then a later allocation load that must not touch need
		write_regs(5'd1, 5'd1);
		send(FUNC_ALLOC, 4'd0, 4'd0, 8'd255);
		send(FUNC_MAX, 4'd0, 4'd0, 8'd0);
		send(FUNC_AVAIL, 4'd15, 4'd0, 8'd0);
		send(FUNC_RUN, '0, '0, '0);
		send(FUNC_ALLOC, 4'd0, 4'd0, 8'd0);
		send(FUNC_RUN, '0, '0, '0);
		// nothing fits, then enough available
		send(FUNC_MAX, 4'd0, 4'd0, 8'd255);
		send(FUNC_RUN, '0, '0, '0);
		send(FUNC_AVAIL, 4'd0, 4'd0, 8'd255);
		send(FUNC_RUN, '0, '0, '0);
		// second pass needed: process 1 frees what process 0 waits for
		write_regs(5'd2, 5'd1);
		send(FUNC_MAX, 4'd0, 4'd0, 8'd3);
		send(FUNC_ALLOC, 4'd1, 4'd0, 8'd5);
		send(FUNC_MAX, 4'd1, 4'd0, 8'd5);
		send(FUNC_AVAIL, 4'd0, 4'd0, 8'd0);
		send(FUNC_RUN, '0, '0, '0);
		// counts above the table size clamp to 16
		write_regs(5'd31, 5'd31);
		send(FUNC_RUN, '0, '0, '0);
		write_regs(5'd16, 5'd16);
		send(FUNC_ALLOC, 4'd15, 4'd15, 8'd255);
		send(FUNC_MAX, 4'd15, 4'd15, 8'd255);
		send(FUNC_AVAIL, 4'd15, 4'd15, 8'd255);
		send(FUNC_RUN, '0, '0, '0);

		while (n_items < ITEM_TARGET || n_results < RESULT_TARGET)
			run_scenario();

		settle();
		if (board.mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
